// File: hw/rtl/sobel_gradient_magnitude_defines.svh
// Assertion macros shared by the Sobel gradient magnitude RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef SOBEL_GRADIENT_MAGNITUDE_DEFINES_SVH
`define SOBEL_GRADIENT_MAGNITUDE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SGM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SGM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// A condition that must never hold out of reset.
`define SGM_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// File: hw/rtl/sgm_pkg.sv
// Types, constants and the Sobel kernel function for the gradient magnitude block.
// Depends on nothing; imported by sobel_gradient_magnitude.
`timescale 1ns / 1ps
`default_nettype none

package sgm_pkg;

  // Request kinds.
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_RST  = 12'd640;
  localparam logic [CFG_DATA_W-1:0] IMAGE_HEIGHT_RST = 12'd480;

  // Result queue.
  localparam int unsigned FIFO_AW    = 2;
  localparam int unsigned FIFO_DEPTH = 4;

  typedef logic [7:0] pix_t;
  // One window column; element 0 is the top row.
  typedef pix_t [2:0] col_t;
  // Three columns; element 0 is the left column.
  typedef col_t [2:0] win_t;

  typedef struct packed {
    logic [7:0] mag;
    logic       frame_end;
    logic       run_last;
  } res_t;

  // Control carried from the accept stage to the memory-data stage.
  typedef struct packed {
    logic drain;   // drain request with a result pending
    logic v0;      // first result slot valid
    logic v1;      // second result slot valid (end of row)
    logic last0;   // first result is the last of its request
    logic fe;      // first result closes the frame
    logic top_ok;  // row two above exists
    logic mid_ok;  // row above exists
    logic lft1;    // column to the left exists
    logic lft2;    // column two to the left exists
    logic rgt;     // column to the right exists (drain only)
  } s1_ctl_t;

  // Mean of |gx| and |gy| rounded half up, saturated at 255.
  function automatic logic [7:0] sobel_mag(input col_t lc, input col_t mc, input col_t rc);
    logic [9:0]         xp;
    logic [9:0]         xn;
    logic [9:0]         yp;
    logic [9:0]         yn;
    logic signed [10:0] gx;
    logic signed [10:0] gy;
    logic [9:0]         ax;
    logic [9:0]         ay;
    logic [10:0]        s;
    xp = {2'b00, rc[0]} + {1'b0, rc[1], 1'b0} + {2'b00, rc[2]};
    xn = {2'b00, lc[0]} + {1'b0, lc[1], 1'b0} + {2'b00, lc[2]};
    yp = {2'b00, lc[2]} + {1'b0, mc[2], 1'b0} + {2'b00, rc[2]};
    yn = {2'b00, lc[0]} + {1'b0, mc[0], 1'b0} + {2'b00, rc[0]};
    gx = $signed({1'b0, xp}) - $signed({1'b0, xn});
    gy = $signed({1'b0, yp}) - $signed({1'b0, yn});
    ax = gx[10] ? 10'(-gx) : gx[9:0];
    ay = gy[10] ? 10'(-gy) : gy[9:0];
    s  = {1'b0, ax} + {1'b0, ay} + 11'd1;
    return (s[10:9] != 2'b00) ? 8'hFF : s[8:1];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sobel_gradient_magnitude.sv
// Streaming 3x3 Sobel gradient magnitude with two line stores in one dual-read memory.
// Depends on sgm_pkg and sobel_gradient_magnitude_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "sobel_gradient_magnitude_defines.svh"

// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_stall  in_kind, in_pixel
// out_     output     out_valid/out_stall  out_magnitude, out_frame_end, out_run_last
// cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One request is taken per clock while in_stall is low. Each is read from the line store
// at its accept edge, and the next cycle combines the memory word with the window, writes
// the column back and pushes up to two results into the result queue. The single write
// port of the line store (one read-modify-write per pixel) sets that rate.
// Reset is synchronous and clears counters, window and queue; the line store needs no pass.
// in_stall rises only when the four-entry result queue could not absorb two more results;
// out_stall holds the head result in place.

module sobel_gradient_magnitude
  import sgm_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Pixel and drain requests.
  input  wire logic                  in_valid,
  output      logic                  in_stall,
  input  wire logic                  in_kind,
  input  wire logic [7:0]            in_pixel,
  // Results.
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      logic [7:0]            out_magnitude,
  output      logic                  out_frame_end,
  output      logic                  out_run_last,
  // Configuration writes.
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Column index width, and a width that also holds the row length itself.
  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned EW = AW + 1;
  // Row index width, and a width that also holds the frame height itself.
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned HW = RW + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are always taken.
  // ---------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] img_w_r;
  logic [CFG_DATA_W-1:0] img_h_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= IMAGE_WIDTH_RST;
      img_h_r <= IMAGE_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  img_w_r <= cfg_data;
        REG_IMAGE_HEIGHT: img_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // A zero size counts as one, and sizes above MAX_WIDTH or MAX_HEIGHT saturate there.
  logic [EW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  always_comb begin
    if (img_w_r == '0) begin
      w_eff = EW'(1);
    end else if (img_w_r > MAX_WIDTH) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = EW'(img_w_r);
    end
    if (img_h_r == '0) begin
      h_eff = HW'(1);
    end else if (img_h_r > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(img_h_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Accept stage: raster counters, drain counter and the line store addresses.
  // ---------------------------------------------------------------------------
  logic          in_acc;
  logic [AW-1:0] col_r,   col_nxt;
  logic [RW-1:0] row_r,   row_nxt;
  logic [EW-1:0] drain_r, drain_nxt;
  logic [AW-1:0] col_eff;
  logic [RW-1:0] row_eff;
  logic [EW-1:0] drain_dec;
  logic          row_end;
  logic          last_row;
  logic [AW-1:0] rd_a_addr;
  logic [AW-1:0] rd_b_addr;
  s1_ctl_t       s1_ctl_r, s1_ctl_nxt;
  logic          s1_vld_r, s1_vld_nxt;
  logic [7:0]    s1_px_r;
  logic [AW-1:0] s1_addr_r;

  assign in_acc = in_valid && !in_stall;

  // A pixel that arrives while a drain is pending opens a new frame.
  assign col_eff   = (drain_r != '0) ? '0 : col_r;
  assign row_eff   = (drain_r != '0) ? '0 : row_r;
  assign drain_dec = drain_r - EW'(1);
  assign row_end   = ({1'b0, col_eff} + EW'(1)) >= w_eff;
  assign last_row  = ({1'b0, row_eff} + HW'(1)) >= h_eff;

  // Port A reads the current column, port B the one to its right (drain only).
  assign rd_a_addr = (in_kind == KIND_DRAIN) ? col_r : col_eff;
  assign rd_b_addr = col_r + AW'(1);

  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    drain_nxt  = drain_r;
    s1_ctl_nxt = '0;
    s1_vld_nxt = 1'b0;
    if (in_acc) begin
      if (in_kind == KIND_DRAIN) begin
        // A drain with nothing pending is dropped without a result.
        if (drain_r != '0) begin
          s1_vld_nxt        = 1'b1;
          s1_ctl_nxt.drain  = 1'b1;
          s1_ctl_nxt.v0     = 1'b1;
          s1_ctl_nxt.last0  = 1'b1;
          s1_ctl_nxt.fe     = (drain_dec == '0);
          s1_ctl_nxt.top_ok = (row_r != '0);
          s1_ctl_nxt.mid_ok = 1'b1;
          s1_ctl_nxt.lft1   = (col_r != '0);
          s1_ctl_nxt.rgt    = (drain_dec != '0) &&
                              (({1'b0, col_r} + EW'(1)) < EW'(MAX_WIDTH));
          drain_nxt = drain_dec;
          if (drain_dec == '0) begin
            col_nxt = '0;
            row_nxt = '0;
          end else begin
            col_nxt = col_r + AW'(1);
          end
        end
      end else begin
        s1_vld_nxt        = 1'b1;
        s1_ctl_nxt.v0     = (row_eff != '0) && (col_eff != '0);
        s1_ctl_nxt.v1     = (row_eff != '0) && row_end;
        s1_ctl_nxt.last0  = !row_end;
        s1_ctl_nxt.top_ok = (row_eff > RW'(1));
        s1_ctl_nxt.mid_ok = (row_eff != '0);
        s1_ctl_nxt.lft1   = (col_eff != '0);
        s1_ctl_nxt.lft2   = (col_eff > AW'(1));
        drain_nxt = '0;
        row_nxt   = row_eff;
        if (row_end) begin
          col_nxt = '0;
          if (last_row) begin
            // The last row waits in the line store for one drain per column.
            drain_nxt = w_eff;
          end else begin
            row_nxt = row_eff + RW'(1);
          end
        end else begin
          col_nxt = col_eff + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      drain_r  <= '0;
      s1_ctl_r <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      drain_r  <= drain_nxt;
      s1_ctl_r <= s1_ctl_nxt;
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px_r   <= in_pixel;
      s1_addr_r <= rd_a_addr;
    end
  end

  // ---------------------------------------------------------------------------
  // Line store: each word holds {row two above, row above} for one column.
  // Reads return the old word on a same-address write, so the word being
  // written back this cycle is forwarded to the next stage.
  // ---------------------------------------------------------------------------
  logic [15:0]   line_mem [MAX_WIDTH];
  logic [15:0]   mem_a_r;
  logic [15:0]   mem_b_r;
  logic          wr_en;
  logic [15:0]   wr_data;
  logic          fwd_a_r;
  logic          fwd_b_r;
  logic [15:0]   fwd_data_r;
  logic [15:0]   dat_a;
  logic [15:0]   dat_b;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[s1_addr_r] <= wr_data;
    end
    mem_a_r <= line_mem[rd_a_addr];
    mem_b_r <= line_mem[rd_b_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_a_r <= 1'b0;
      fwd_b_r <= 1'b0;
    end else begin
      fwd_a_r <= wr_en && (s1_addr_r == rd_a_addr);
      fwd_b_r <= wr_en && (s1_addr_r == rd_b_addr);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= wr_data;
  end

  assign dat_a = fwd_a_r ? fwd_data_r : mem_a_r;
  assign dat_b = fwd_b_r ? fwd_data_r : mem_b_r;

  // The row above moves down to "two above", and the new pixel becomes "above".
  assign wr_en   = s1_vld_r && !s1_ctl_r.drain;
  assign wr_data = {dat_a[7:0], s1_px_r};

  // ---------------------------------------------------------------------------
  // Window and kernel stage.
  // ---------------------------------------------------------------------------
  win_t        win_r, win_nxt;
  col_t        new_col;
  logic [15:0] drain_prev_r;
  col_t        drn_l, drn_m, drn_r;
  res_t        res0, res1;
  logic [7:0]  pix_mag0;
  logic [7:0]  pix_mag1;
  logic [7:0]  drn_mag;

  always_comb begin
    new_col[0] = s1_ctl_r.top_ok ? dat_a[15:8] : 8'd0;
    new_col[1] = s1_ctl_r.mid_ok ? dat_a[7:0]  : 8'd0;
    new_col[2] = s1_px_r;
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = new_col;
  end

  assign pix_mag0 = sobel_mag(s1_ctl_r.lft2 ? win_nxt[0] : '0, win_nxt[1], win_nxt[2]);
  assign pix_mag1 = sobel_mag(s1_ctl_r.lft1 ? win_nxt[1] : '0, win_nxt[2], '0);

  // Drains see the last row with zeros below; the left column comes from the
  // previous drain's port A word.
  always_comb begin
    drn_l[0] = (s1_ctl_r.lft1 && s1_ctl_r.top_ok) ? drain_prev_r[15:8] : 8'd0;
    drn_l[1] = s1_ctl_r.lft1 ? drain_prev_r[7:0] : 8'd0;
    drn_l[2] = 8'd0;
    drn_m[0] = s1_ctl_r.top_ok ? dat_a[15:8] : 8'd0;
    drn_m[1] = dat_a[7:0];
    drn_m[2] = 8'd0;
    drn_r[0] = (s1_ctl_r.rgt && s1_ctl_r.top_ok) ? dat_b[15:8] : 8'd0;
    drn_r[1] = s1_ctl_r.rgt ? dat_b[7:0] : 8'd0;
    drn_r[2] = 8'd0;
  end

  assign drn_mag = sobel_mag(drn_l, drn_m, drn_r);

  always_comb begin
    res0.mag       = s1_ctl_r.drain ? drn_mag : pix_mag0;
    res0.frame_end = s1_ctl_r.fe;
    res0.run_last  = s1_ctl_r.last0;
    res1.mag       = pix_mag1;
    res1.frame_end = 1'b0;
    res1.run_last  = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (wr_en) begin
      win_r <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r && s1_ctl_r.drain) begin
      drain_prev_r <= dat_a;
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue. Space for two results is reserved at accept time, so the
  // kernel stage never has to wait.
  // ---------------------------------------------------------------------------
  res_t               fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, wp_nxt;
  logic [FIFO_AW-1:0] rp_r, rp_nxt;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;
  logic [1:0]         push_n;
  logic               pop;
  res_t               push_first;
  res_t               head;

  assign push_n     = {1'b0, s1_ctl_r.v0} + {1'b0, s1_ctl_r.v1};
  assign push_first = s1_ctl_r.v0 ? res0 : res1;
  assign pop        = out_valid && !out_stall;

  assign wp_nxt  = wp_r + FIFO_AW'(push_n);
  assign rp_nxt  = rp_r + FIFO_AW'(pop);
  assign cnt_nxt = cnt_r + (FIFO_AW + 1)'(push_n) - (FIFO_AW + 1)'(pop);

  // Take a request only if the queue still has room for two results after
  // the kernel stage has pushed.
  assign in_stall = ({1'b0, cnt_r} + (FIFO_AW + 2)'(push_n)) >
                    ((FIFO_AW + 2)'(FIFO_DEPTH / 2) + (FIFO_AW + 2)'(pop));

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_r[wp_r] <= push_first;
    end
    if (push_n == 2'd2) begin
      fifo_r[wp_r + FIFO_AW'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign head          = fifo_r[rp_r];
  assign out_valid     = (cnt_r != '0);
  assign out_magnitude = head.mag;
  assign out_frame_end = head.frame_end;
  assign out_run_last  = head.run_last;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `SGM_ASSERT_NEVER(a_queue_bound, clk, rst_n, cnt_r > (FIFO_AW + 1)'(FIFO_DEPTH), "result queue overflow")
  `SGM_ASSERT_NXT(a_first_row_silent, clk, rst_n, in_acc && (in_kind == KIND_PIXEL) && (drain_r == '0) && (row_r == '0), !s1_ctl_r.v0 && !s1_ctl_r.v1, "first row pixel produced a result")
  `SGM_ASSERT_IMP(a_drain_single, clk, rst_n, s1_vld_r && s1_ctl_r.drain, s1_ctl_r.v0 && !s1_ctl_r.v1 && !wr_en, "drain must give one result and not write the line store")

endmodule

`default_nettype wire
